>>> rtl/abkf_pkg.sv
// Shared types and constants for the angle and bias Kalman filter.
`default_nettype none
package abkf_pkg;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned NOISE_W = 31;
  localparam int unsigned DT_W = 16;
  localparam int unsigned DT_FRAC = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned DIV_STEPS = 64;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd2;

  localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST = 31'd268435;
  localparam logic [NOISE_W-1:0] BIAS_NOISE_RST = 31'd805306;
  localparam logic [NOISE_W-1:0] MEAS_NOISE_RST = 31'd80530637;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;

  // Clamp a 34-bit signed sum to 32 bits.
  function automatic logic signed [DATA_W-1:0] sat34(input logic signed [33:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 34'sh007fffffff) r = S32_MAX;
    else if (v < -34'sh0080000000) r = S32_MIN;
    else r = v[DATA_W-1:0];
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/angle_bias_kalman_filter.sv
// Top level of the angle and gyro bias Kalman filter.
// Use: the input channel (in_valid/in_ready) carries one word per IMU
// sample: accelerometer angle, gyro rate and time step. Each accepted
// word gives exactly one output word on out_valid/out_ready, the new
// filtered angle in signed Q16.16.
// The three noise registers are written via cfg_we/cfg_idx/cfg_data by the
// user while the filter is idle (unenforced); index 3 writes are dropped.
// Datapath: one shared 32x32 multiplier (product then rounding) runs ten
// products under a small sequencer, and a restoring divider computes each
// of the two gains. Both divisions are skipped when the innovation variance
// is not positive. in_ready is low from acceptance until the result enters
// the output register and rises as out_valid is set, so a new word is
// accepted only after the previous one is through.
// Output: the result sits in an output register; the next input word is
// accepted while it still waits, so a stalled receiver only blocks the
// following word's result, not the acceptance.
// Reset (rst_n low, synchronous) clears angle, bias and covariance and
// loads the default noise values.
`default_nettype none
module angle_bias_kalman_filter #(
  parameter int unsigned COV_FRAC_BITS = 28
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [abkf_pkg::DATA_W-1:0]    in_measured_angle,
  input  wire logic signed [abkf_pkg::DATA_W-1:0]    in_gyro_rate,
  input  wire logic [abkf_pkg::DT_W-1:0]             in_time_step,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [abkf_pkg::DATA_W-1:0]         out_filtered_angle,
  input  wire logic                                  cfg_we,
  input  wire logic [abkf_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  wire logic [abkf_pkg::NOISE_W-1:0]          cfg_data
);
  typedef enum logic [4:0] {
    S_IDLE, S_M_ANG, S_W_ANG, S_M_T, S_W_T, S_M_PAA, S_W_PAA,
    S_M_PBB, S_W_PBB, S_GAIN0, S_DIV0, S_GAIN1, S_DIV1, S_M_K0Y, S_W_K0Y,
    S_M_K1Y, S_W_K1Y, S_M_C0, S_W_C0, S_M_C1, S_W_C1, S_M_C2, S_W_C2,
    S_M_C3, S_W_C3, S_OUT
  } state_t;

  state_t state_r;
  logic [abkf_pkg::NOISE_W-1:0] q_ang_r, q_bias_r, r_meas_r;
  logic signed [31:0] ang_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [31:0] meas_r, rate_r, t_r, k0_r, k1_r, y_r, s_r, p00h_r, p01h_r;
  logic [abkf_pkg::DT_W-1:0] dt_r;
  logic out_valid_r;
  logic signed [31:0] out_r;

  logic signed [31:0] ma, mb, my;
  logic [5:0] msh;
  logic div_start, div_done;
  logic signed [31:0] div_num, div_quo;

  localparam logic [5:0] SH_DT = 6'(abkf_pkg::DT_FRAC);
  localparam logic [5:0] SH_COV = 6'(COV_FRAC_BITS);

  abkf_mul u_mul (.clk(clk), .a(ma), .b(mb), .shift(msh), .y(my));
  abkf_div #(.COV_FRAC_BITS(COV_FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(s_r),
    .done(div_done), .quo(div_quo));

  // Operand select for the shared multiplier.
  always_comb begin
    ma = '0; mb = '0; msh = SH_DT;
    unique case (state_r)
      S_M_ANG: begin ma = rate_r; mb = 32'(dt_r); end
      S_M_T:   begin ma = 32'(dt_r); mb = p11_r; end
      S_M_PAA: begin ma = 32'(dt_r); mb = t_r; end
      S_M_PBB: begin ma = 32'(q_bias_r); mb = 32'(dt_r); end
      S_M_K0Y: begin ma = k0_r; mb = y_r; msh = SH_COV; end
      S_M_K1Y: begin ma = k1_r; mb = y_r; msh = SH_COV; end
      S_M_C0:  begin ma = k0_r; mb = p00h_r; msh = SH_COV; end
      S_M_C1:  begin ma = k0_r; mb = p01h_r; msh = SH_COV; end
      S_M_C2:  begin ma = k1_r; mb = p00h_r; msh = SH_COV; end
      S_M_C3:  begin ma = k1_r; mb = p01h_r; msh = SH_COV; end
      default: ;
    endcase
  end

  assign div_start = (state_r == S_GAIN0) || (state_r == S_GAIN1);
  assign div_num = (state_r == S_GAIN0) ? p00_r : p10_r;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_filtered_angle = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      q_ang_r <= abkf_pkg::ANGLE_NOISE_RST;
      q_bias_r <= abkf_pkg::BIAS_NOISE_RST;
      r_meas_r <= abkf_pkg::MEAS_NOISE_RST;
      ang_r <= '0; bias_r <= '0;
      p00_r <= '0; p01_r <= '0; p10_r <= '0; p11_r <= '0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          abkf_pkg::REG_ANGLE_NOISE: q_ang_r <= cfg_data;
          abkf_pkg::REG_BIAS_NOISE:  q_bias_r <= cfg_data;
          abkf_pkg::REG_MEAS_NOISE:  r_meas_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          meas_r <= in_measured_angle;
          dt_r <= in_time_step;
          rate_r <= abkf_pkg::sat34(34'(in_gyro_rate) - 34'(bias_r));
          state_r <= S_M_ANG;
        end
        S_M_ANG: state_r <= S_W_ANG;
        S_W_ANG: begin
          ang_r <= abkf_pkg::sat34(34'(ang_r) + 34'(my));
          state_r <= S_M_T;
        end
        S_M_T: state_r <= S_W_T;
        S_W_T: begin
          // advance the off-diagonal terms; t_r takes the inner term, formed
          // from the off-diagonals before this update
          p01_r <= abkf_pkg::sat34(34'(p01_r) - 34'(my));
          p10_r <= abkf_pkg::sat34(34'(p10_r) - 34'(my));
          t_r <= abkf_pkg::sat34(34'(my) - 34'(p01_r) - 34'(p10_r) + 34'(q_ang_r));
          state_r <= S_M_PAA;
        end
        S_M_PAA: state_r <= S_W_PAA;
        S_W_PAA: begin
          p00_r <= abkf_pkg::sat34(34'(p00_r) + 34'(my));
          state_r <= S_M_PBB;
        end
        S_M_PBB: state_r <= S_W_PBB;
        S_W_PBB: begin
          p11_r <= abkf_pkg::sat34(34'(p11_r) + 34'(my));
          s_r <= abkf_pkg::sat34(34'(p00_r) + 34'(r_meas_r));
          y_r <= abkf_pkg::sat34(34'(meas_r) - 34'(ang_r));
          p00h_r <= p00_r;
          p01h_r <= p01_r;
          state_r <= S_GAIN0;
        end
        S_GAIN0: begin
          if (s_r > 0) state_r <= S_DIV0;
          else begin
            k0_r <= '0; k1_r <= '0; state_r <= S_M_K0Y;
          end
        end
        S_DIV0: if (div_done) begin
          k0_r <= div_quo; state_r <= S_GAIN1;
        end
        S_GAIN1: state_r <= S_DIV1;
        S_DIV1: if (div_done) begin
          k1_r <= div_quo; state_r <= S_M_K0Y;
        end
        S_M_K0Y: state_r <= S_W_K0Y;
        S_W_K0Y: begin
          ang_r <= abkf_pkg::sat34(34'(ang_r) + 34'(my));
          state_r <= S_M_K1Y;
        end
        S_M_K1Y: state_r <= S_W_K1Y;
        S_W_K1Y: begin
          bias_r <= abkf_pkg::sat34(34'(bias_r) + 34'(my));
          state_r <= S_M_C0;
        end
        S_M_C0: state_r <= S_W_C0;
        S_W_C0: begin
          p00_r <= abkf_pkg::sat34(34'(p00_r) - 34'(my)); state_r <= S_M_C1;
        end
        S_M_C1: state_r <= S_W_C1;
        S_W_C1: begin
          p01_r <= abkf_pkg::sat34(34'(p01_r) - 34'(my)); state_r <= S_M_C2;
        end
        S_M_C2: state_r <= S_W_C2;
        S_W_C2: begin
          p10_r <= abkf_pkg::sat34(34'(p10_r) - 34'(my)); state_r <= S_M_C3;
        end
        S_M_C3: state_r <= S_W_C3;
        S_W_C3: begin
          p11_r <= abkf_pkg::sat34(34'(p11_r) - 34'(my)); state_r <= S_OUT;
        end
        S_OUT: if (!out_valid_r || out_ready) begin
          // drop into the output register once it is free
          out_r <= ang_r;
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/abkf_mul.sv
// Shared signed multiplier with rounding shift and saturation, registered product.
`default_nettype none
module abkf_mul (
  input  wire logic                              clk,
  input  wire logic signed [abkf_pkg::DATA_W-1:0] a,
  input  wire logic signed [abkf_pkg::DATA_W-1:0] b,
  input  wire logic [5:0]                        shift,
  output logic signed [abkf_pkg::DATA_W-1:0]     y
);
  logic signed [abkf_pkg::PROD_W-1:0] prod_r;
  logic [5:0] shift_r;
  logic signed [abkf_pkg::PROD_W-1:0] rnd;
  logic signed [abkf_pkg::PROD_W-1:0] shifted;

  always_ff @(posedge clk) begin
    prod_r <= abkf_pkg::PROD_W'(a) * abkf_pkg::PROD_W'(b);
    shift_r <= shift;
  end

  always_comb begin
    rnd = prod_r + (abkf_pkg::PROD_W'(1) <<< (shift_r - 6'd1));
    shifted = rnd >>> shift_r;
    if (shifted > 64'sh7fffffff) y = abkf_pkg::S32_MAX;
    else if (shifted < -64'sh80000000) y = abkf_pkg::S32_MIN;
    else y = shifted[abkf_pkg::DATA_W-1:0];
  end
endmodule
`default_nettype wire

>>> rtl/abkf_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero, saturated.
`default_nettype none
module abkf_div #(
  parameter int unsigned COV_FRAC_BITS = 28
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [abkf_pkg::DATA_W-1:0] num,
  input  wire logic signed [abkf_pkg::DATA_W-1:0] den,
  output logic                                   done,
  output logic signed [abkf_pkg::DATA_W-1:0]     quo
);
  localparam int unsigned NW = abkf_pkg::DIV_STEPS;
  logic [NW-1:0] n_r;
  logic [NW-1:0] q_r;
  logic [abkf_pkg::DATA_W:0] rem_r;
  logic [abkf_pkg::DATA_W-1:0] d_r;
  logic neg_r;
  logic [6:0] cnt_r;
  logic busy_r;
  logic [abkf_pkg::DATA_W:0] trial;
  logic [abkf_pkg::DATA_W:0] shifted;
  logic [NW-1:0] mag;

  assign mag = num[abkf_pkg::DATA_W-1]
             ? NW'(-(64'(signed'(num)))) << COV_FRAC_BITS
             : NW'(num) << COV_FRAC_BITS;
  assign shifted = {rem_r[abkf_pkg::DATA_W-1:0], n_r[NW-1]};
  assign trial = shifted - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= 7'(NW);
        n_r <= mag;
        q_r <= '0;
        rem_r <= '0;
        d_r <= den;
        neg_r <= num[abkf_pkg::DATA_W-1];
      end else if (busy_r) begin
        n_r <= n_r << 1;
        if (!trial[abkf_pkg::DATA_W]) begin
          rem_r <= trial;
          q_r <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= shifted;
          q_r <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (neg_r) begin
      if (q_r > 64'h80000000) quo = abkf_pkg::S32_MIN;
      else quo = -signed'(q_r[abkf_pkg::DATA_W-1:0]);
    end else begin
      if (q_r > 64'h7fffffff) quo = abkf_pkg::S32_MAX;
      else quo = q_r[abkf_pkg::DATA_W-1:0];
    end
  end
endmodule
`default_nettype wire

>>> rtl/abkf_checker.sv
// Port-level checks for the angle and bias Kalman filter, bound to the top level.
`default_nettype none
module abkf_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] out_filtered_angle
);
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready stayed high after accept");
  a_no_result_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 !($rose(out_valid))) else $error("result too early");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered_angle))
    else $error("output word changed while stalled");
endmodule
bind angle_bias_kalman_filter abkf_checker u_abkf_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_filtered_angle(out_filtered_angle));
`default_nettype wire
